/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent checks clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check while out of reset
`define ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// check on every edge, reset included
`define ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed");

`endif

/* hw/rtl/nosc_pkg.sv */
// ----------------------------------------------------------------------------
// nosc_pkg
// Types, codes and pitch ratio tables of the four-wave note oscillator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nosc_pkg;

  typedef enum logic [1:0] {
    KIND_TICK     = 2'd0,
    KIND_NOTE_ON  = 2'd1,
    KIND_NOTE_OFF = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    WAVE_SAW      = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_TRIANGLE = 2'd2,
    WAVE_SINE     = 2'd3
  } wave_e;

  typedef enum logic [2:0] {
    CFG_OSC_EN    = 3'd0,
    CFG_WAVE_SEL  = 3'd1,
    CFG_CENTS     = 3'd2,
    CFG_GAIN      = 3'd3,
    CFG_REF_INC   = 3'd4
  } cfg_idx_e;

  localparam int unsigned StepW = 31;
  localparam int unsigned RatioW = 17;

  typedef struct packed {
    logic       vld;
    logic [1:0] sel;
    logic       active;
  } wave_ctl_t;

  typedef struct packed {
    logic busy;
    logic upd;
  } pitch_stat_t;

  // 2^(n/12) in Q16
  function automatic logic [RatioW-1:0] semi_val(logic [3:0] idx);
    logic [RatioW-1:0] v;
    case (idx)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd69433;
      4'd2:    v = 17'd73562;
      4'd3:    v = 17'd77936;
      4'd4:    v = 17'd82570;
      4'd5:    v = 17'd87480;
      4'd6:    v = 17'd92682;
      4'd7:    v = 17'd98193;
      4'd8:    v = 17'd104032;
      4'd9:    v = 17'd110218;
      4'd10:   v = 17'd116772;
      4'd11:   v = 17'd123716;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

  // 2^(10n/1200) in Q16
  function automatic logic [RatioW-1:0] tens_val(logic [3:0] idx);
    logic [RatioW-1:0] v;
    case (idx)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd65916;
      4'd2:    v = 17'd66297;
      4'd3:    v = 17'd66682;
      4'd4:    v = 17'd67068;
      4'd5:    v = 17'd67456;
      4'd6:    v = 17'd67847;
      4'd7:    v = 17'd68240;
      4'd8:    v = 17'd68635;
      4'd9:    v = 17'd69033;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

  // 2^(n/1200) in Q16
  function automatic logic [RatioW-1:0] ones_val(logic [3:0] idx);
    logic [RatioW-1:0] v;
    case (idx)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd65574;
      4'd2:    v = 17'd65612;
      4'd3:    v = 17'd65650;
      4'd4:    v = 17'd65688;
      4'd5:    v = 17'd65726;
      4'd6:    v = 17'd65764;
      4'd7:    v = 17'd65802;
      4'd8:    v = 17'd65840;
      4'd9:    v = 17'd65878;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/nosc_pitch.sv */
// ----------------------------------------------------------------------------
// nosc_pitch
// Pipelined note to phase step conversion: octave and cent split, three
// ratio multiplies, octave shift and saturation into the step register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nosc_pitch
  import nosc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [6:0]        note_i,
  input  logic [11:0]       cents_i,
  input  logic [StepW-1:0]  ref_inc_i,
  output pitch_stat_t       stat_o,
  output logic [StepW-1:0]  step_o
);

  logic [4:0]        vld_q;
  logic [3:0]        p1_oct_q, p2_oct_q, p3_oct_q, p4_oct_q, p5_oct_q;
  logic [10:0]       p1_rem_q;
  logic [RatioW-1:0] p2_semi_q, p2_tens_q, p2_ones_q, p3_ones_q;
  logic [RatioW-1:0] p3_m1_q, p4_m2_q;
  logic [47:0]       p5_prod_q;
  logic [StepW-1:0]  step_q, step_d;

  logic [15:0]       total;
  logic [13:0]       oct_ge;
  logic [3:0]        oct_cnt;
  logic [10:0]       rem;
  logic [10:0]       semi_ge;
  logic [8:0]        tens_ge;
  logic [3:0]        semi_idx, tens_idx, ones_idx;
  logic [6:0]        r2;
  logic [33:0]       m1_full, m2_full;
  logic [5:0]        shamt;
  logic [55:0]       wide;

  // split total cents into octave and remainder
  always_comb begin
    total = 16'(note_i) * 16'd100 + {{4{cents_i[11]}}, cents_i} + 16'd2700;
    for (int k = 1; k <= 14; k++) begin
      oct_ge[k-1] = total[14:0] >= 15'(k * 1200);
    end
    oct_cnt = 4'($countones(oct_ge));
    rem = 11'(total[14:0] - 15'(oct_cnt) * 15'd1200);
  end

  // remainder into semitone, tens and ones digits
  always_comb begin
    for (int k = 1; k <= 11; k++) begin
      semi_ge[k-1] = p1_rem_q >= 11'(k * 100);
    end
    semi_idx = 4'($countones(semi_ge));
    r2 = 7'(p1_rem_q - 11'(semi_idx) * 11'd100);
    for (int k = 1; k <= 9; k++) begin
      tens_ge[k-1] = r2 >= 7'(k * 10);
    end
    tens_idx = 4'($countones(tens_ge));
    ones_idx = 4'(r2 - 7'(tens_idx) * 7'd10);
  end

  assign m1_full = 34'(p2_semi_q) * 34'(p2_tens_q);
  assign m2_full = 34'(p3_m1_q) * 34'(p3_ones_q);

  // octave shift: prod >> (16 - oct), with oct = count - 8
  always_comb begin
    shamt = 6'(6'd32 - 6'(p5_oct_q));
    wide = {p5_prod_q, 8'h00} >> shamt;
    if (|wide[55:StepW]) begin
      step_d = {StepW{1'b1}};
    end else begin
      step_d = wide[StepW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      step_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], start_i};
      if (vld_q[4]) begin
        step_q <= step_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p1_oct_q  <= oct_cnt;
    p1_rem_q  <= rem;
    p2_oct_q  <= p1_oct_q;
    p2_semi_q <= semi_val(semi_idx);
    p2_tens_q <= tens_val(tens_idx);
    p2_ones_q <= ones_val(ones_idx);
    p3_oct_q  <= p2_oct_q;
    p3_m1_q   <= m1_full[16+RatioW-1:16];
    p3_ones_q <= p2_ones_q;
    p4_oct_q  <= p3_oct_q;
    p4_m2_q   <= m2_full[16+RatioW-1:16];
    p5_oct_q  <= p4_oct_q;
    p5_prod_q <= 48'(ref_inc_i) * 48'(p4_m2_q);
  end

  assign stat_o.busy = |vld_q;
  assign stat_o.upd  = vld_q[4];
  assign step_o      = step_q;

endmodule

/* hw/rtl/nosc_wave.sv */
// ----------------------------------------------------------------------------
// nosc_wave
// Sine table read, waveform shaping and gain scaling of one tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nosc_wave
  import nosc_pkg::*;
#(
  parameter int unsigned SINE_TABLE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  wave_ctl_t   ctl_i,
  input  logic [15:0] phase_i,
  input  logic [15:0] gain_i,
  output logic        vld_o,
  output logic [15:0] sample_o
);

  localparam int unsigned IdxW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned MulW = 14 + IdxW;

  typedef logic [14:0] sine_arr_t [SINE_TABLE_DEPTH+1];

  function automatic sine_arr_t build_sine();
    sine_arr_t tab;
    longint    u, u2, t, t2, r, q;
    int        i;
    for (i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      u  = (longint'(i) << 16) / SINE_TABLE_DEPTH;
      u2 = (u * u) >> 16;
      t  = 42047 - ((4640 * u2) >> 16);
      t2 = 102944 - ((t * u2) >> 16);
      r  = (t2 * u) >> 16;
      q  = (r + 1) >> 1;
      if (q > 32767) begin
        q = 32767;
      end
      tab[i] = 15'(q);
    end
    return tab;
  endfunction

  localparam sine_arr_t SINE_ROM = build_sine();

  logic [MulW-1:0] idx_mul;
  logic [IdxW-1:0] idx_raw, idx;
  logic [14:0]     rom_q;
  wave_ctl_t       b_ctl_q;
  logic [15:0]     b_p_q;

  logic [16:0]     y;
  logic [17:0]     tri_hi;
  logic            neg;
  logic [15:0]     mag, m;
  logic [31:0]     scaled;

  // mirror the quarter-wave index on odd quadrants
  always_comb begin
    idx_mul = MulW'(phase_i[13:0]) * MulW'(SINE_TABLE_DEPTH);
    idx_raw = IdxW'(idx_mul >> 14);
    if (phase_i[14]) begin
      idx = IdxW'(SINE_TABLE_DEPTH) - idx_raw;
    end else begin
      idx = idx_raw;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rom_q <= SINE_ROM[idx];
      b_p_q <= phase_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_ctl_q <= '0;
    end else if (en_i) begin
      b_ctl_q <= ctl_i;
    end
  end

  always_comb begin
    tri_hi = 18'd98304 - {1'b0, b_p_q, 1'b0};
    case (b_ctl_q.sel)
      WAVE_SAW: begin
        y = {1'b0, b_p_q} - 17'h08000;
      end
      WAVE_SQUARE: begin
        y = b_p_q[15] ? 17'h18000 : 17'h07FFF;
      end
      WAVE_TRIANGLE: begin
        if (!b_p_q[15]) begin
          y = {1'b0, b_p_q[14:0], 1'b0} - 17'h08000;
        end else if ($signed(tri_hi) > 18'sd32767) begin
          y = 17'h07FFF;
        end else begin
          y = tri_hi[16:0];
        end
      end
      WAVE_SINE: begin
        y = {2'b00, rom_q};
        if (b_p_q[15]) begin
          y = 17'(-y);
        end
      end
      default: begin
        y = '0;
      end
    endcase
    neg    = y[16];
    mag    = neg ? 16'(-y) : y[15:0];
    scaled = 32'(mag) * 32'(gain_i);
    m      = scaled[31:16];
    if (!b_ctl_q.active) begin
      sample_o = '0;
    end else if (neg) begin
      sample_o = 16'(-m);
    end else begin
      sample_o = m;
    end
  end

  assign vld_o = b_ctl_q.vld;

endmodule

/* hw/rtl/note_oscillator_four_wave_top.sv */
// ----------------------------------------------------------------------------
// note_oscillator_four_wave_top: monophonic four-waveform note oscillator
// A tick's sample passes the wave stage and the output register to m_axis.
// Ticks and note-offs go one per cycle while m_axis is not stalled; a note-on holds
// s_axis_tready low until the pitch pipeline (three multiplies) updates the step.
// Reset is asynchronous, active low; registers with a reset value take it at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module note_oscillator_four_wave_top
  import nosc_pkg::*;
#(
  parameter int unsigned SINE_TABLE_DEPTH = 256,
  parameter int unsigned PHASE_BITS       = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [6:0] note
  input  logic [1:0]        s_axis_tuser,   // [1:0] kind
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata,   // [15:0] sample
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [StepW-1:0]  cfg_data_i
);

  logic              osc_en_q;
  logic [1:0]        wave_sel_q;
  logic [11:0]       cents_q;
  logic [15:0]       gain_q;
  logic [StepW-1:0]  ref_inc_q;

  logic              a_vld_q;
  logic [1:0]        a_kind_q;
  logic [6:0]        a_note_q;

  logic [PHASE_BITS-1:0] acc_q, acc_d;
  logic [6:0]        note_q, note_d;
  logic              gate_q, gate_d;

  logic              out_vld_q;
  logic [15:0]       out_data_q;

  logic              en, s_acc, cfg_acc, pitch_start;
  pitch_stat_t       pitch_stat;
  logic [StepW-1:0]  step;
  wave_ctl_t         wave_ctl;
  logic              wave_vld;
  logic [15:0]       wave_sample;

  assign en            = !out_vld_q || m_axis_tready;
  assign pitch_start   = en && a_vld_q && (a_kind_q == KIND_NOTE_ON);
  assign s_axis_tready = en && !pitch_stat.busy &&
                         !(a_vld_q && (a_kind_q == KIND_NOTE_ON));
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign cfg_acc       = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      osc_en_q   <= 1'b1;
      wave_sel_q <= WAVE_SAW;
      cents_q    <= '0;
      gain_q     <= 16'd32768;
      ref_inc_q  <= 31'd39370534;
    end else if (cfg_acc) begin
      case (cfg_index_i)
        CFG_OSC_EN:   osc_en_q   <= cfg_data_i[0];
        CFG_WAVE_SEL: wave_sel_q <= cfg_data_i[1:0];
        CFG_CENTS:    cents_q    <= cfg_data_i[11:0];
        CFG_GAIN:     gain_q     <= cfg_data_i[15:0];
        CFG_REF_INC:  ref_inc_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // apply the request held in the input stage
  always_comb begin
    acc_d  = acc_q;
    note_d = note_q;
    gate_d = gate_q;
    if (en && a_vld_q) begin
      case (a_kind_q)
        KIND_TICK: begin
          acc_d = acc_q + PHASE_BITS'(step);
        end
        KIND_NOTE_ON: begin
          note_d = a_note_q;
          gate_d = 1'b1;
        end
        KIND_NOTE_OFF: begin
          if (a_note_q == note_q) begin
            gate_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      acc_q     <= '0;
      note_q    <= '0;
      gate_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      note_q <= note_d;
      gate_q <= gate_d;
      if (en) begin
        a_vld_q   <= s_acc;
        out_vld_q <= wave_vld;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      a_kind_q <= s_axis_tuser;
      a_note_q <= s_axis_tdata[6:0];
    end
    if (en) begin
      out_data_q <= wave_sample;
    end
  end

  assign wave_ctl.vld    = a_vld_q && (a_kind_q == KIND_TICK);
  assign wave_ctl.sel    = wave_sel_q;
  assign wave_ctl.active = osc_en_q && gate_q;

  nosc_pitch u_pitch (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (pitch_start),
    .note_i    (a_note_q),
    .cents_i   (cents_q),
    .ref_inc_i (ref_inc_q),
    .stat_o    (pitch_stat),
    .step_o    (step)
  );

  nosc_wave #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_wave (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .ctl_i    (wave_ctl),
    .phase_i  (acc_d[PHASE_BITS-1 -: 16]),
    .gain_i   (gain_q),
    .vld_o    (wave_vld),
    .sample_o (wave_sample)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  `ASSERT_RST(a_step_update, pitch_start |-> ##5 pitch_stat.upd)
  `ASSERT_RST(a_tick_to_wave, (en && wave_ctl.vld) |=> wave_vld)
  `ASSERT_RST(a_no_accept_busy, pitch_stat.busy |-> !s_acc)
  `ASSERT_RST(a_sample_range, m_axis_tvalid |-> (m_axis_tdata != 16'h8000))

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the four-wave note oscillator. A queue of note-on,
// note-off, tick and reserved requests feeds the input stream with random gaps; a
// bit-true pitch and waveform predictor computes each tick's sample and the
// output stream is compared in order. Settings change between phases only
// once the block has drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import nosc_pkg::*;

  localparam int          SineDepth     = 256;
  localparam int          SettleCycles  = 16;
  localparam int          WatchdogLimit = 4000;
  localparam int          RandomPhases  = 20;
  localparam int          PhaseRequests = 55;
  localparam logic [1:0]  KindReserved  = 2'd3;
  localparam logic [63:0] StepCeiling   = 64'd2147483647;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] note;
  } osc_req_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'd0;   // [6:0] note
  logic [1:0]  s_axis_tuser  = 2'd0;   // [1:0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [15:0] sample
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i   = 3'd0;
  logic [30:0] cfg_data_i    = 31'd0;

  note_oscillator_four_wave_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  int unsigned semi_q16 [12] = '{65536, 69433, 73562, 77936, 82570, 87480,
                                 92682, 98193, 104032, 110218, 116772, 123716};
  int unsigned tens_q16 [10] = '{65536, 65916, 66297, 66682, 67068,
                                 67456, 67847, 68240, 68635, 69033};
  int unsigned ones_q16 [10] = '{65536, 65574, 65612, 65650, 65688,
                                 65726, 65764, 65802, 65840, 65878};
  int sine_quarter [SineDepth+1];

  logic               osc_en_q  = 1'b1;
  wave_e              wave_q    = WAVE_SAW;
  logic signed [11:0] cents_q   = 12'sd0;
  logic [15:0]        gain_q    = 16'd32768;
  logic [30:0]        ref_inc_q = 31'd39370534;
  logic [31:0]        phase_q   = 32'd0;
  logic [31:0]        step_q    = 32'd0;
  logic [6:0]         held_note = 7'd0;
  logic               gate_q    = 1'b0;

  osc_req_t    osc_requests [$];
  logic [15:0] expected_samples [$];
  osc_req_t    active_req;
  logic [6:0]  last_on_note = 7'd0;
  bit          idle_on = 1'b1;
  int          src_hold = 0;
  int          sink_hold = 0;
  int          quiet_cycles = 0;
  int          mismatch_count = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic void predict_request(osc_req_t r);
    int          total;
    int          octave;
    int unsigned rem;
    logic [63:0] ratio;
    logic [63:0] prod;
    logic [15:0] p;
    int          idx;
    int          wave;
    int          mag;
    int          smp;
    case (r.kind)
      KIND_NOTE_ON: begin
        held_note = r.note;
        gate_q    = 1'b1;
        total  = int'(r.note) * 100 - 6900 + int'(cents_q) + 9600;
        octave = total / 1200 - 8;
        rem    = total % 1200;
        ratio  = (64'(semi_q16[rem / 100]) * 64'(tens_q16[(rem % 100) / 10])) >> 16;
        ratio  = (ratio * 64'(ones_q16[rem % 10])) >> 16;
        prod   = 64'(ref_inc_q) * ratio;
        if (octave >= 0) begin
          prod = (prod << octave) >> 16;
        end else begin
          prod = prod >> (16 - octave);
        end
        if (prod > StepCeiling) prod = StepCeiling;
        step_q = prod[31:0];
      end
      KIND_NOTE_OFF: begin
        if (r.note == held_note) gate_q = 1'b0;
      end
      KIND_TICK: begin
        phase_q = phase_q + step_q;
        p = phase_q[31:16];
        case (wave_q)
          WAVE_SAW: wave = int'(p) - 32768;
          WAVE_SQUARE: wave = (p < 16'd32768) ? 32767 : -32768;
          WAVE_TRIANGLE: begin
            wave = (p < 16'd32768) ? 2 * int'(p) - 32768 : 98304 - 2 * int'(p);
            if (wave > 32767) wave = 32767;
          end
          default: begin
            idx = (int'(p[13:0]) * SineDepth) >> 14;
            if (p[14]) idx = SineDepth - idx;
            wave = sine_quarter[idx];
            if (p[15]) wave = -wave;
          end
        endcase
        smp = 0;
        if (osc_en_q && gate_q) begin
          mag = (wave < 0) ? -wave : wave;
          mag = int'((64'(mag) * 64'(gain_q)) >> 16);
          smp = (wave < 0) ? -mag : mag;
          if (smp > 32767) smp = 32767;
        end
        expected_samples.push_back(16'(smp));
      end
      default: ;
    endcase
  endfunction

  task automatic queue_req(input logic [1:0] kind, input logic [6:0] note);
    osc_req_t r;
    r.kind = kind;
    r.note = note;
    osc_requests.push_back(r);
  endtask

  task automatic queue_random_run(input int count);
    int         roll;
    logic [6:0] n;
    n = 7'($urandom_range(0, 127));
    queue_req(KIND_NOTE_ON, n);
    last_on_note = n;
    for (int k = 1; k < count; k++) begin
      roll = $urandom_range(0, 99);
      n    = 7'($urandom_range(0, 127));
      if (roll < 10) begin
        queue_req(KIND_NOTE_ON, n);
        last_on_note = n;
      end else if (roll < 18) begin
        queue_req(KIND_NOTE_OFF, (roll < 15) ? last_on_note : n);
      end else if (roll < 21) begin
        queue_req(KindReserved, n);
      end else begin
        queue_req(KIND_TICK, n);
      end
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [30:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_OSC_EN:   osc_en_q  = val[0];
      CFG_WAVE_SEL: wave_q    = wave_e'(val[1:0]);
      CFG_CENTS:    cents_q   = val[11:0];
      CFG_GAIN:     gain_q    = val[15:0];
      CFG_REF_INC:  ref_inc_q = val;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic program_voice(input logic en, input wave_e wv,
                               input logic signed [11:0] cents,
                               input logic [15:0] gain, input logic [30:0] incr);
    write_reg(CFG_OSC_EN, {30'd0, en});
    write_reg(CFG_WAVE_SEL, {29'd0, wv});
    write_reg(CFG_CENTS, {19'd0, cents});
    write_reg(CFG_GAIN, {15'd0, gain});
    write_reg(CFG_REF_INC, incr);
  endtask

  // hold until the block has drained, then let the pitch pipeline finish
  task automatic settle();
    @(negedge clk_i);
    while (osc_requests.size() != 0 || s_axis_tvalid || expected_samples.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_request(active_req);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_hold > 0) begin
          src_hold--;
          s_axis_tvalid <= 1'b0;
        end else if (osc_requests.size() > 0) begin
          active_req = osc_requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {1'b0, active_req.note};
          s_axis_tuser  <= active_req.kind;
          if (idle_on && $urandom_range(0, 9) == 0) src_hold = $urandom_range(1, 18);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    logic [15:0] want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("sample %0d with no tick pending",
                                    $signed(m_axis_tdata)));
        end else begin
          want = expected_samples.pop_front();
          if (m_axis_tdata !== want)
            report_mismatch($sformatf("sample got %0d expected %0d",
                                      $signed(m_axis_tdata), $signed(want)));
        end
      end
      if (sink_hold > 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        sink_hold = $urandom_range(1, 18) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    longint unsigned u;
    longint unsigned u2;
    longint unsigned t;
    longint unsigned t2;
    longint unsigned q;
    logic               en;
    wave_e              wv;
    logic signed [11:0] cents;
    logic [15:0]        gain;
    logic [30:0]        incr;
    int                 roll;

    for (int i = 0; i <= SineDepth; i++) begin
      u  = (longint'(i) << 16) / SineDepth;
      u2 = (u * u) >> 16;
      t  = 42047 - ((4640 * u2) >> 16);
      t2 = 102944 - ((t * u2) >> 16);
      q  = (((t2 * u) >> 16) + 1) >> 1;
      if (q > 32767) q = 32767;
      sine_quarter[i] = int'(q);
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, gate closed
    queue_req(KIND_TICK, 7'd127);
    queue_req(KIND_NOTE_OFF, 7'd0);
    settle();

    // quarter-wave steps land on the triangle peak and the sine quadrant edges
    program_voice(1'b1, WAVE_TRIANGLE, 12'sd0, 16'hFFFF, 31'h4000_0000);
    queue_req(KIND_NOTE_ON, 7'd69);
    repeat (4) queue_req(KIND_TICK, 7'd0);
    settle();
    program_voice(1'b1, WAVE_SINE, 12'sd0, 16'hFFFF, 31'h4000_0000);
    queue_req(KIND_NOTE_ON, 7'd69);
    repeat (4) queue_req(KIND_TICK, 7'd0);
    settle();

    program_voice(1'b1, WAVE_SAW, 12'sd0, 16'd32768, 31'd39370534);
    queue_req(KIND_NOTE_ON, 7'd69);
    queue_req(KIND_TICK, 7'd0);
    queue_req(KIND_NOTE_OFF, 7'd70);
    queue_req(KIND_TICK, 7'd0);
    queue_req(KIND_NOTE_OFF, 7'd69);
    queue_req(KIND_TICK, 7'd0);
    queue_req(KindReserved, 7'd127);
    queue_req(KIND_TICK, 7'd0);
    queue_req(KIND_NOTE_ON, 7'd0);
    queue_req(KIND_TICK, 7'd0);
    queue_req(KIND_NOTE_ON, 7'd127);
    queue_req(KIND_TICK, 7'd0);
    settle();

    // step saturation
    program_voice(1'b1, WAVE_SQUARE, 12'sd0, 16'hFFFF, 31'h7FFF_FFFF);
    queue_req(KIND_NOTE_ON, 7'd127);
    queue_req(KIND_TICK, 7'd0);
    queue_req(KIND_TICK, 7'd0);
    settle();

    for (int ph = 0; ph < RandomPhases; ph++) begin
      idle_on = (ph < 16) && (ph % 8 != 7);
      en    = ($urandom_range(0, 7) != 0);
      wv    = wave_e'($urandom_range(0, 3));
      cents = 12'(int'($urandom_range(0, 2400)) - 1200);
      gain  = 16'($urandom);
      roll  = $urandom_range(0, 9);
      if (roll < 7)       incr = 31'($urandom_range(1000000, 200000000));
      else if (roll == 7) incr = 31'($urandom);
      else if (roll == 8) incr = 31'h7FFF_FFFF;
      else                incr = 31'($urandom_range(0, 1000));
      case (ph)
        0:  en = 1'b0;
        1:  cents = 12'sh7FF;
        2:  cents = 12'sh800;
        3:  gain = 16'd0;
        4:  incr = 31'd0;
        5:  begin
          gain = 16'hFFFF;
          wv   = WAVE_SINE;
        end
        18: cents = -12'sd1200;
        19: cents = 12'sd1200;
        default: ;
      endcase
      program_voice(en, wv, cents, gain, incr);
      queue_random_run(PhaseRequests);
      settle();
    end

    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* note_oscillator_four_wave_top.f */
+incdir+hw/rtl
hw/rtl/nosc_pkg.sv
hw/rtl/nosc_pitch.sv
hw/rtl/nosc_wave.sv
hw/rtl/note_oscillator_four_wave_top.sv
tb/sv/testbench.sv
